[hw/rtl/wtc_pkg.sv]
package wtc_pkg;

  // field and state widths
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 12;
  localparam int CNT_W     = 11;
  localparam int HIT_W     = 23;
  localparam int SUM_W     = 33;
  localparam int OUT_W     = 11;
  localparam int IDX_W     = 3;
  // effective frame sizes up to 8192 need 14 bits
  localparam int DIM_W     = 14;
  // divider step counter holds SUM_W
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_THRESHOLD      = 3'd0,
    REG_FRAME_WIDTH    = 3'd1,
    REG_FRAME_HEIGHT   = 3'd2,
    REG_WINDOW_X_START = 3'd3,
    REG_WINDOW_X_END   = 3'd4,
    REG_WINDOW_Y_START = 3'd5,
    REG_WINDOW_Y_END   = 3'd6
  } cfg_idx_t;

  // configuration reset values
  localparam logic [PIX_W-1:0] THRESHOLD_RST    = 8'd128;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [CFG_W-1:0] WINDOW_END_RST   = 12'd2048;

  typedef enum logic {
    ST_ACCUM,
    ST_DIVIDE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic pix_acc;
    logic frame_close;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
  } sts_t;

endpackage

[hw/rtl/wtc_div.sv]
module wtc_div
  import wtc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [HIT_W-1:0] divisor,
  output logic             busy,
  output logic [SUM_W-1:0] quotient
);

  logic [SUM_W-1:0]     work;
  logic [SUM_W-1:0]     work_next;
  logic [HIT_W-1:0]     rem;
  logic [HIT_W-1:0]     rem_next;
  logic [HIT_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] steps;
  logic [HIT_W:0]       rem_sh;
  logic                 fits;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh    = {rem, work[SUM_W-1]};
    fits      = rem_sh >= {1'b0, dvs};
    rem_next  = fits ? HIT_W'(rem_sh - {1'b0, dvs}) : rem_sh[HIT_W-1:0];
    work_next = {work[SUM_W-2:0], fits};
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= DIV_CNT_W'(SUM_W);
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      dvs  <= divisor;
      rem  <= '0;
    end else if (steps != '0) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign busy     = steps != '0;
  assign quotient = work;

endmodule

[hw/rtl/wtc_dp.sv]
module wtc_dp
  import wtc_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic [PIX_W-1:0] pixel,
  output logic [OUT_W-1:0] center_x,
  output logic [OUT_W-1:0] center_y,
  output logic             empty_set
);

  localparam logic [DIM_W-1:0] MaxW = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MaxH = DIM_W'(MAX_HEIGHT);

  logic [PIX_W-1:0] threshold;
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [CFG_W-1:0] window_x_start;
  logic [CFG_W-1:0] window_x_end;
  logic [CFG_W-1:0] window_y_start;
  logic [CFG_W-1:0] window_y_end;

  logic [CNT_W-1:0] column_counter;
  logic [CNT_W-1:0] column_counter_next;
  logic [CNT_W-1:0] row_counter;
  logic [CNT_W-1:0] row_counter_next;
  logic [HIT_W-1:0] hit_count;
  logic [HIT_W-1:0] hit_count_next;
  logic [SUM_W-1:0] column_sum;
  logic [SUM_W-1:0] column_sum_next;
  logic [SUM_W-1:0] row_sum;
  logic [SUM_W-1:0] row_sum_next;
  logic [HIT_W-1:0] hit_snap;

  logic [DIM_W-1:0] fw;
  logic [DIM_W-1:0] fh;
  logic [DIM_W-1:0] xe;
  logic [DIM_W-1:0] ye;
  logic [CNT_W:0]   col_p1;
  logic [CNT_W:0]   row_p1;
  logic             in_win;
  logic             hit;

  logic             x_busy;
  logic             y_busy;
  logic [SUM_W-1:0] x_quot;
  logic [SUM_W-1:0] y_quot;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= THRESHOLD_RST;
      frame_width    <= FRAME_WIDTH_RST;
      frame_height   <= FRAME_HEIGHT_RST;
      window_x_start <= '0;
      window_x_end   <= WINDOW_END_RST;
      window_y_start <= '0;
      window_y_end   <= WINDOW_END_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_THRESHOLD:      threshold      <= cfg_data[PIX_W-1:0];
        REG_FRAME_WIDTH:    frame_width    <= cfg_data;
        REG_FRAME_HEIGHT:   frame_height   <= cfg_data;
        REG_WINDOW_X_START: window_x_start <= cfg_data;
        REG_WINDOW_X_END:   window_x_end   <= cfg_data;
        REG_WINDOW_Y_START: window_y_start <= cfg_data;
        REG_WINDOW_Y_END:   window_y_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective frame size and clipped window ends
  always_comb begin
    if (frame_width == '0) begin
      fw = DIM_W'(1);
    end else if (DIM_W'(frame_width) > MaxW) begin
      fw = MaxW;
    end else begin
      fw = DIM_W'(frame_width);
    end
    if (frame_height == '0) begin
      fh = DIM_W'(1);
    end else if (DIM_W'(frame_height) > MaxH) begin
      fh = MaxH;
    end else begin
      fh = DIM_W'(frame_height);
    end
    xe = (DIM_W'(window_x_end) < fw) ? DIM_W'(window_x_end) : fw;
    ye = (DIM_W'(window_y_end) < fh) ? DIM_W'(window_y_end) : fh;
  end

  // window and threshold test
  always_comb begin
    in_win = (CFG_W'(column_counter) >= window_x_start) &&
             (DIM_W'(column_counter) < xe) &&
             (CFG_W'(row_counter) >= window_y_start) &&
             (DIM_W'(row_counter) < ye) &&
             (pixel >= threshold);
    hit = cmd.pix_acc && in_win;
  end

  // accumulate and advance raster position
  always_comb begin
    hit_count_next  = hit_count;
    column_sum_next = column_sum;
    row_sum_next    = row_sum;
    if (hit) begin
      hit_count_next  = hit_count + 1'b1;
      column_sum_next = column_sum + SUM_W'(column_counter);
      row_sum_next    = row_sum + SUM_W'(row_counter);
    end
    col_p1              = {1'b0, column_counter} + 1'b1;
    row_p1              = {1'b0, row_counter} + 1'b1;
    column_counter_next = col_p1[CNT_W-1:0];
    row_counter_next    = row_counter;
    if (DIM_W'(col_p1) >= fw) begin
      column_counter_next = '0;
      row_counter_next    = (DIM_W'(row_p1) >= MaxH) ? '0 : row_p1[CNT_W-1:0];
    end
  end

  // frame state, cleared after the frame end transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
      hit_count      <= '0;
      column_sum     <= '0;
      row_sum        <= '0;
    end else if (cmd.frame_close) begin
      column_counter <= '0;
      row_counter    <= '0;
      hit_count      <= '0;
      column_sum     <= '0;
      row_sum        <= '0;
    end else if (cmd.pix_acc) begin
      column_counter <= column_counter_next;
      row_counter    <= row_counter_next;
      hit_count      <= hit_count_next;
      column_sum     <= column_sum_next;
      row_sum        <= row_sum_next;
    end
  end

  // hit count of the closed frame
  always_ff @(posedge clk) begin
    if (cmd.frame_close) begin
      hit_snap <= hit_count_next;
    end
  end

  // one divider per axis, running in lockstep
  wtc_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.frame_close),
    .dividend (column_sum_next),
    .divisor  (hit_count_next),
    .busy     (x_busy),
    .quotient (x_quot)
  );

  wtc_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.frame_close),
    .dividend (row_sum_next),
    .divisor  (hit_count_next),
    .busy     (y_busy),
    .quotient (y_quot)
  );

  assign sts.div_busy = x_busy || y_busy;

  // result register, centre reads as zero when outside the frame or when no pixel hit
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      empty_set <= hit_snap == '0;
      center_x  <= (hit_snap == '0 || x_quot >= SUM_W'(fw)) ? '0 : x_quot[OUT_W-1:0];
      center_y  <= (hit_snap == '0 || y_quot >= SUM_W'(fh)) ? '0 : y_quot[OUT_W-1:0];
    end
  end

endmodule

[hw/rtl/wtc_ctrl.sv]
module wtc_ctrl
  import wtc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic frame_end,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    cmd.pix_acc     = 1'b0;
    cmd.frame_close = 1'b0;
    cmd.out_load    = 1'b0;
    unique case (state)
      ST_ACCUM: begin
        in_ready        = 1'b1;
        cmd.pix_acc     = in_valid;
        cmd.frame_close = in_valid && frame_end;
        if (in_valid && frame_end) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (!sts.div_busy && (!out_valid || out_ready)) begin
          cmd.out_load = 1'b1;
          state_next   = ST_ACCUM;
        end
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  // result held until the output transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // no pixel taken while the dividers work on the closed frame
  a_stall_after_close: assert property (@(posedge clk) disable iff (rst)
    cmd.frame_close |=> !in_ready && sts.div_busy)
    else $error("input not stalled after frame end");

  // result loaded only from a finished division
  a_load_when_done: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.div_busy && state == ST_DIVIDE)
    else $error("result loaded while dividers busy");

  // a new result only comes from a load
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output valid without result load");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && out_valid |-> out_ready)
    else $error("pending result overwritten");

endmodule

[hw/rtl/windowed_threshold_centroid_unit.sv]
// channel  | handshake              | payload
// ---------+------------------------+---------------------------------
// input    | in_valid / in_ready    | pixel, frame_end
// output   | out_valid / out_ready  | center_x, center_y, empty_set
// config   | cfg_write              | cfg_index, cfg_data
//
// one pixel per cycle while a frame accumulates
// a frame end transaction holds in_ready low while the two bit-serial
// dividers produce one quotient bit per cycle, and longer if the
// previous result has not yet been taken from the output register
// rst is synchronous; it clears counters, sums and configuration registers to defaults
// a stalled output does not block pixels of the current frame; it lengthens the stall after the next frame end
module windowed_threshold_centroid_unit
  import wtc_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] pixel,
  input  logic             frame_end,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] center_x,
  output logic [OUT_W-1:0] center_y,
  output logic             empty_set,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  wtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .frame_end (frame_end),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wtc_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixel),
    .center_x  (center_x),
    .center_y  (center_y),
    .empty_set (empty_set)
  );

endmodule
